>>> hw/rtl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// Bencode stream parser package
// Shared types, codes and constants of the bencode tokenizer.
// ----------------------------------------------------------------------------
package bsp_pkg;

  // Default depth of the nesting stack.
  localparam int unsigned MaxDepthDef = 32;

  // Result queue depth; a power of two so that the pointers wrap freely.
  localparam int unsigned ResDepth = 4;

  // Stream and register port widths.
  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 72;
  localparam int unsigned TuserOutW = 4;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  // Bits of a nesting stack entry.
  localparam int unsigned StkDictBit = 0;
  localparam int unsigned StkKeyBit  = 1;

  // Characters that the grammar reacts to.
  localparam logic [7:0] ChInt   = 8'h69;
  localparam logic [7:0] ChList  = 8'h6C;
  localparam logic [7:0] ChDict  = 8'h64;
  localparam logic [7:0] ChEnd   = 8'h65;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Range limits, held one nibble wider than the value so that the
  // multiply-accumulate cannot wrap before the compare.
  localparam logic [67:0] IntPosMax = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] IntNegMax = 68'h0_8000_0000_0000_0000;
  localparam logic [35:0] LenMax    = 36'h0_FFFF_FFFF;

  // Register indexes (byte address bit 2).
  localparam logic RegTopMustBeDict = 1'b0;
  localparam logic RegMaxNesting    = 1'b1;

  typedef enum logic [2:0] {
    TK_INT,
    TK_STR_HDR,
    TK_STR_BYTE,
    TK_LIST_OPEN,
    TK_DICT_OPEN,
    TK_CLOSE,
    TK_ERROR
  } tok_kind_e;

  typedef enum logic [3:0] {
    ERR_UNKNOWN_TOKEN,
    ERR_BAD_INT,
    ERR_INT_TRUNC,
    ERR_BAD_STR_LEN,
    ERR_STR_TRUNC,
    ERR_LIST_OPEN,
    ERR_DICT_OPEN,
    ERR_KEY_NOT_STR,
    ERR_TOO_DEEP,
    ERR_INT_OVF,
    ERR_LEN_OVF,
    ERR_TOP_NOT_DICT
  } err_code_e;

  typedef enum logic [2:0] {
    MODE_VALUE,
    MODE_INT_START,
    MODE_INT_SIGN,
    MODE_INT_DIGITS,
    MODE_STR_LEN,
    MODE_STR_DATA
  } mode_e;

  typedef enum logic [1:0] {
    RUN_ACTIVE,
    RUN_DONE,
    RUN_ERROR
  } run_e;

  typedef struct packed {
    logic       top_must_be_dict;
    logic [5:0] max_nesting;
  } cfg_t;

  typedef struct packed {
    tok_kind_e   kind;
    logic [63:0] value;
    logic [5:0]  level;
    logic        key;
    logic        send;
    logic        top;
    logic        last;
  } token_t;

  function automatic token_t mk_tok(tok_kind_e kind, logic [63:0] value,
                                    logic [5:0] level, logic key, logic send,
                                    logic top);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.level = level;
    t.key   = key;
    t.send  = send;
    t.top   = top;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

>>> hw/rtl/bsp_stack_mem.sv
// ----------------------------------------------------------------------------
// Nesting stack memory
// Synchronous memory of stack entries below the top, one write and one read
// port, registered read data with write-to-read forwarding.
// ----------------------------------------------------------------------------
module bsp_stack_mem #(
  parameter int unsigned DEPTH = bsp_pkg::MaxDepthDef,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rdata_o
);
  import bsp_pkg::*;

  logic [1:0] stk_q [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      stk_q[waddr_i] <= wdata_i;
    end
  end

  // A write to the entry being read shows up in the same read.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= stk_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bsp_result_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results a cycle and hands out
// one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module bsp_result_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_cnt_i,
  input  bsp_pkg::token_t push0_i,
  input  bsp_pkg::token_t push1_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bsp_pkg::token_t out_o
);
  import bsp_pkg::*;

  localparam int unsigned PW   = $clog2(ResDepth);
  localparam int unsigned CNTW = $clog2(ResDepth + 1);

  token_t          fifo_q [ResDepth];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_o       = fifo_q[rptr_q];
  // Room for the worst case of two results from the next item.
  assign space_o     = (count_q <= CNTW'(ResDepth - 2));

  always_comb begin
    wptr_d  = wptr_q + PW'(push_cnt_i);
    rptr_d  = rptr_q + PW'(pop);
    count_d = count_q + CNTW'(push_cnt_i) - CNTW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      fifo_q[wptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      fifo_q[wptr_q + PW'(1)] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

>>> hw/rtl/bsp_parse_core.sv
// ----------------------------------------------------------------------------
// Bencode parse core
// Per-byte grammar update: mode, integer and length accumulators, top of the
// nesting stack in flops and the rest in the stack memory.
// ----------------------------------------------------------------------------
module bsp_parse_core #(
  parameter int unsigned MAX_DEPTH = bsp_pkg::MaxDepthDef,
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_data_i,
  input  bsp_pkg::cfg_t   cfg_i,
  input  logic [1:0]      below_i,
  output logic            stk_we_o,
  output logic [AW-1:0]   stk_waddr_o,
  output logic [1:0]      stk_wdata_o,
  output logic [AW-1:0]   stk_raddr_o,
  output bsp_pkg::token_t res0_o,
  output bsp_pkg::token_t res1_o,
  output logic [1:0]      res_cnt_o
);
  import bsp_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CW = (DW > 6) ? DW : 6;

  mode_e         mode_q, mode_d;
  run_e          status_q, status_d;
  logic [63:0]   accum_q, accum_d;
  logic          neg_q, neg_d;
  logic [31:0]   strrem_q, strrem_d;
  logic [DW-1:0] depth_q, depth_d;
  logic          key_q, key_d;
  logic [1:0]    tos_q, tos_d;

  logic          is_dgt;
  logic [3:0]    dgt;
  logic          top_dict, key_pos, depth0, at_limit;
  logic [5:0]    mn_eff;
  logic [CW-1:0] lim_w;
  logic [67:0]   int_prod, int_lim;
  logic [35:0]   len_prod;
  logic [31:0]   rem_dec;
  logic          rem_zero, int_ovf, len_ovf;
  logic [DW-1:0] depth_inc, depth_dec;
  logic [5:0]    lvl, lvl_dec;

  logic          do_push, push_dict, do_close, do_finish, do_fail, do_digit, trunc;
  err_code_e     fail_code, tcode;
  logic          tok_v;
  token_t        tok, trunc_tok;

  // Operand preparation; all of it depends on registered state and the byte.
  always_comb begin
    is_dgt    = (in_byte_i >= ChZero) && (in_byte_i <= ChNine);
    dgt       = in_byte_i[3:0];
    depth0    = (depth_q == '0);
    top_dict  = !depth0 && tos_q[StkDictBit];
    key_pos   = top_dict && tos_q[StkKeyBit];
    mn_eff    = (cfg_i.max_nesting == 6'd0) ? 6'd1 : cfg_i.max_nesting;
    lim_w     = (CW'(mn_eff) > CW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : CW'(mn_eff);
    at_limit  = (CW'(depth_q) >= lim_w);
    int_prod  = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + 68'(dgt);
    int_lim   = neg_q ? IntNegMax : IntPosMax;
    int_ovf   = (int_prod > int_lim);
    len_prod  = ({4'b0, strrem_q} << 3) + ({4'b0, strrem_q} << 1) + 36'(dgt);
    len_ovf   = (len_prod > LenMax);
    rem_dec   = strrem_q - 32'd1;
    rem_zero  = (rem_dec == 32'd0);
    depth_inc = depth_q + DW'(1);
    depth_dec = depth_q - DW'(1);
    lvl       = 6'(depth_q);
    lvl_dec   = 6'(depth_dec);
  end

  always_comb begin
    mode_d    = mode_q;
    status_d  = status_q;
    accum_d   = accum_q;
    neg_d     = neg_q;
    strrem_d  = strrem_q;
    depth_d   = depth_q;
    key_d     = key_q;
    tos_d     = tos_q;
    do_push   = 1'b0;
    push_dict = 1'b0;
    do_close  = 1'b0;
    do_finish = 1'b0;
    do_fail   = 1'b0;
    do_digit  = 1'b0;
    fail_code = ERR_UNKNOWN_TOKEN;
    tok_v     = 1'b0;
    tok       = mk_tok(TK_INT, 64'd0, lvl, 1'b0, 1'b0, 1'b0);
    trunc     = 1'b0;
    tcode     = ERR_LIST_OPEN;
    trunc_tok = mk_tok(TK_ERROR, 64'd0, lvl, 1'b0, 1'b0, 1'b0);

    if (accept_i && (status_q == RUN_ACTIVE)) begin
      unique case (mode_q)
        MODE_VALUE: begin
          if (depth0 && cfg_i.top_must_be_dict && (in_byte_i != ChDict)) begin
            do_fail   = 1'b1;
            fail_code = ERR_TOP_NOT_DICT;
          end else if (key_pos) begin
            if (in_byte_i == ChEnd) begin
              do_close = 1'b1;
            end else if (is_dgt) begin
              strrem_d = 32'(dgt);
              key_d    = 1'b1;
              mode_d   = MODE_STR_LEN;
            end else if ((in_byte_i == ChInt) || (in_byte_i == ChList) ||
                         (in_byte_i == ChDict)) begin
              do_fail   = 1'b1;
              fail_code = ERR_KEY_NOT_STR;
            end else begin
              do_fail   = 1'b1;
              fail_code = ERR_UNKNOWN_TOKEN;
            end
          end else if ((in_byte_i == ChEnd) && !depth0 && !top_dict) begin
            do_close = 1'b1;
          end else if (in_byte_i == ChInt) begin
            mode_d  = MODE_INT_START;
            accum_d = 64'd0;
            neg_d   = 1'b0;
          end else if ((in_byte_i == ChList) || (in_byte_i == ChDict)) begin
            if (at_limit) begin
              do_fail   = 1'b1;
              fail_code = ERR_TOO_DEEP;
            end else begin
              do_push   = 1'b1;
              push_dict = (in_byte_i == ChDict);
            end
          end else if (is_dgt) begin
            strrem_d = 32'(dgt);
            key_d    = 1'b0;
            mode_d   = MODE_STR_LEN;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_UNKNOWN_TOKEN;
          end
        end
        MODE_INT_START: begin
          if (in_byte_i == ChMinus) begin
            neg_d  = 1'b1;
            mode_d = MODE_INT_SIGN;
          end else if (is_dgt) begin
            do_digit = 1'b1;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_INT;
          end
        end
        MODE_INT_SIGN: begin
          if (is_dgt) begin
            do_digit = 1'b1;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_INT;
          end
        end
        MODE_INT_DIGITS: begin
          if (is_dgt) begin
            do_digit = 1'b1;
          end else if (in_byte_i == ChEnd) begin
            tok_v     = 1'b1;
            tok       = mk_tok(TK_INT, neg_q ? (64'd0 - accum_q) : accum_q, lvl,
                               1'b0, 1'b0, depth0);
            do_finish = 1'b1;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_INT;
          end
        end
        MODE_STR_LEN: begin
          if (is_dgt) begin
            if (len_ovf) begin
              do_fail   = 1'b1;
              fail_code = ERR_LEN_OVF;
            end else begin
              strrem_d = len_prod[31:0];
            end
          end else if (in_byte_i == ChColon) begin
            tok_v = 1'b1;
            tok   = mk_tok(TK_STR_HDR, 64'(strrem_q), lvl, key_q,
                           strrem_q == 32'd0, (strrem_q == 32'd0) && depth0);
            if (strrem_q == 32'd0) begin
              do_finish = 1'b1;
            end else begin
              mode_d = MODE_STR_DATA;
            end
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_STR_LEN;
          end
        end
        MODE_STR_DATA: begin
          strrem_d  = rem_dec;
          tok_v     = 1'b1;
          tok       = mk_tok(TK_STR_BYTE, 64'(in_byte_i), lvl, key_q, rem_zero,
                             rem_zero && depth0);
          do_finish = rem_zero;
        end
        default: begin
          do_fail   = 1'b1;
          fail_code = ERR_UNKNOWN_TOKEN;
        end
      endcase

      if (do_digit) begin
        if (int_ovf) begin
          do_fail   = 1'b1;
          fail_code = ERR_INT_OVF;
        end else begin
          accum_d = int_prod[63:0];
          mode_d  = MODE_INT_DIGITS;
        end
      end

      // Pop: the entry below becomes the new top, taken from the memory's
      // registered read port.
      if (do_close) begin
        depth_d   = depth_dec;
        tos_d     = below_i;
        tok_v     = 1'b1;
        tok       = mk_tok(TK_CLOSE, 64'd0, lvl_dec, 1'b0, 1'b0, depth_dec == '0);
        do_finish = 1'b1;
      end

      if (do_push) begin
        tok_v   = 1'b1;
        tok     = mk_tok(push_dict ? TK_DICT_OPEN : TK_LIST_OPEN, 64'd0, lvl,
                         1'b0, 1'b0, 1'b0);
        tos_d   = {push_dict, push_dict};
        depth_d = depth_inc;
      end

      // A finished value ends the run at depth zero, else flips dict key/value.
      if (do_finish) begin
        mode_d = MODE_VALUE;
        key_d  = 1'b0;
        if (depth_d == '0) begin
          status_d = RUN_DONE;
        end else if (tos_d[StkDictBit]) begin
          tos_d[StkKeyBit] = ~tos_d[StkKeyBit];
        end
      end

      if (do_fail) begin
        tok_v    = 1'b1;
        tok      = mk_tok(TK_ERROR, 64'(fail_code), lvl, 1'b0, 1'b0, 1'b0);
        status_d = RUN_ERROR;
      end

      if ((status_d == RUN_ACTIVE) && end_of_data_i) begin
        trunc = 1'b1;
        unique case (mode_d)
          MODE_INT_START, MODE_INT_SIGN, MODE_INT_DIGITS: tcode = ERR_INT_TRUNC;
          MODE_STR_LEN:  tcode = ERR_BAD_STR_LEN;
          MODE_STR_DATA: tcode = ERR_STR_TRUNC;
          default: begin
            tcode = ((depth_d != '0) && tos_d[StkDictBit]) ? ERR_DICT_OPEN
                                                          : ERR_LIST_OPEN;
          end
        endcase
        trunc_tok = mk_tok(TK_ERROR, 64'(tcode), 6'(depth_d), 1'b0, 1'b0, 1'b0);
      end
    end

    // The last byte of a buffer returns the parse state to its reset value.
    if (accept_i && end_of_data_i) begin
      mode_d   = MODE_VALUE;
      status_d = RUN_ACTIVE;
      accum_d  = 64'd0;
      neg_d    = 1'b0;
      strrem_d = 32'd0;
      depth_d  = '0;
      key_d    = 1'b0;
    end
  end

  // Results of this byte, the second one only for a truncation.
  always_comb begin
    res0_o    = tok_v ? tok : trunc_tok;
    res1_o    = trunc_tok;
    res_cnt_o = {tok_v & trunc, tok_v ^ trunc};
    if (tok_v && trunc) begin
      res1_o.last = 1'b1;
    end else begin
      res0_o.last = 1'b1;
    end
  end

  // A push spills the old top into the memory; the read port always fetches
  // the entry below the next top so that a pop in the next cycle finds it.
  assign stk_we_o    = do_push && !depth0;
  assign stk_waddr_o = AW'(depth_dec);
  assign stk_wdata_o = tos_q;
  assign stk_raddr_o = AW'(depth_d - DW'(2));

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_VALUE;
      status_q <= RUN_ACTIVE;
      accum_q  <= 64'd0;
      neg_q    <= 1'b0;
      strrem_q <= 32'd0;
      depth_q  <= '0;
      key_q    <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      status_q <= status_d;
      accum_q  <= accum_d;
      neg_q    <= neg_d;
      strrem_q <= strrem_d;
      depth_q  <= depth_d;
      key_q    <= key_d;
    end
  end

endmodule

>>> hw/rtl/bencode_stream_parser_top.sv
// ----------------------------------------------------------------------------
// Bencode stream parser
// Byte-serial bencode tokenizer with a bounded nesting stack, a result queue
// and a small register port.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Contents
// s_axis    in   tvalid/tready      tdata[7:0] in_byte, tlast end_of_data
// m_axis    out  tvalid/tready      tdata value/level/string_end/top_complete,
//                                   tuser kind/is_dict_key, tlast last_result
// apb       in   psel/penable/pready register 0 top_must_be_dict,
//                                   register 1 max_nesting
//
// Every byte is parsed in the cycle it is accepted, so a new byte can be
// taken every clock. A byte gives at most two results; they go into a
// four-entry result queue, and the input is ready while the queue has room
// for two. The output drains one result per cycle, which sets the rate when
// bytes give two results or the output stalls. The nesting stack keeps its
// top entry in flops and the rest in a memory with a registered read; the
// entry under the top is always prefetched, so a close in one cycle and
// another in the next need no wait. After reset the block is ready at once:
// the stack memory needs no clearing because the depth count starts at zero.
// ----------------------------------------------------------------------------
module bencode_stream_parser_top #(
  parameter int unsigned MAX_DEPTH = bsp_pkg::MaxDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bsp_pkg::TdataInW-1:0]   s_axis_tdata,   // [7:0] in_byte
  input  logic                           s_axis_tlast,   // end_of_data
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bsp_pkg::TdataOutW-1:0]  m_axis_tdata,   // [63:0] token_value,
                                                         // [69:64] nest_level,
                                                         // [70] string_end,
                                                         // [71] top_complete
  output logic [bsp_pkg::TuserOutW-1:0]  m_axis_tuser,   // [2:0] token_kind,
                                                         // [3] is_dict_key
  output logic                           m_axis_tlast,   // last_result
  // Register port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsp_pkg::PaddrW-1:0]     paddr,
  input  logic [bsp_pkg::PdataW-1:0]     pwdata,
  output logic [bsp_pkg::PdataW-1:0]     prdata,
  output logic                           pready
);
  import bsp_pkg::*;

  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  cfg_t          cfg_q, cfg_d;
  logic          cfg_wr;
  logic          accept;
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [1:0]    stk_wdata, stk_rdata;
  token_t        res0, res1, res_out;
  logic [1:0]    res_cnt;

  // Registers are written in the access phase; pready is always high, so
  // the low address bits are not decoded and bit 2 picks the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        RegTopMustBeDict: cfg_d.top_must_be_dict = pwdata[0];
        RegMaxNesting:    cfg_d.max_nesting      = pwdata[5:0];
        default:          cfg_d                  = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegTopMustBeDict: prdata = PdataW'(cfg_q.top_must_be_dict);
      RegMaxNesting:    prdata = PdataW'(cfg_q.max_nesting);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top_must_be_dict <= 1'b0;
      cfg_q.max_nesting      <= 6'd32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  bsp_parse_core #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (s_axis_tdata),
    .end_of_data_i (s_axis_tlast),
    .cfg_i         (cfg_q),
    .below_i       (stk_rdata),
    .stk_we_o      (stk_we),
    .stk_waddr_o   (stk_waddr),
    .stk_wdata_o   (stk_wdata),
    .stk_raddr_o   (stk_raddr),
    .res0_o        (res0),
    .res1_o        (res1),
    .res_cnt_o     (res_cnt)
  );

  bsp_stack_mem #(
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  bsp_result_fifo u_results (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .space_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res_out)
  );

  // Output packing, highest field first.
  assign m_axis_tdata = {res_out.top, res_out.send, res_out.level, res_out.value};
  assign m_axis_tuser = {res_out.key, res_out.kind};
  assign m_axis_tlast = res_out.last;

  // An item that produced results makes a result available next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (res_cnt != 2'd0)) |=> m_axis_tvalid)
    else $error("results of an accepted item did not reach the output");

  // The input only stalls while results are waiting in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty result queue");

  // An error token always ends the results of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[2:0] == TK_ERROR)) |-> m_axis_tlast)
    else $error("error token not marked as the last result");

endmodule
